// File: design/usan_pkg.sv
// shared types, constants and byte classification for the utf-8 sanitiser
package usan_pkg;

  localparam int BUDGET_WIDTH = 16;
  localparam int CFG_WIDTH    = 16;
  localparam int BUDGET_RESET = 200;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  // replacement character as utf-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // sequence length codes from the lead byte
  localparam logic [2:0] LEN_BAD   = 3'd0;
  localparam logic [2:0] LEN_ASCII = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;
  localparam logic [2:0] LEN_REPL  = 3'd3;

  // at most one command per input beat: r_pre replacements, an optional
  // pass-through sequence, then r_post replacements
  typedef struct packed {
    logic [3:0][7:0] seq;
    logic [2:0]      seq_len;
    logic [2:0]      r_pre;
    logic [1:0]      r_post;
    logic            eos;
    logic            all_valid;
  } cmd_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = LEN_BAD;
    if (b inside {[8'h00:8'h7F]}) len = LEN_ASCII;
    else if (b inside {[8'hC2:8'hDF]}) len = LEN_TWO;
    else if (b inside {[8'hE0:8'hEF]}) len = LEN_THREE;
    else if (b inside {[8'hF0:8'hF4]}) len = LEN_FOUR;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b inside {[8'h80:8'hBF]};
  endfunction

  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic ok;
    case (lead)
      8'hE0: begin
        ok = b inside {[8'hA0:8'hBF]};
      end
      8'hED: begin
        ok = b inside {[8'h80:8'h9F]};
      end
      8'hF0: begin
        ok = b inside {[8'h90:8'hBF]};
      end
      8'hF4: begin
        ok = b inside {[8'h80:8'h8F]};
      end
      default: begin
        ok = is_cont(b);
      end
    endcase
    return ok;
  endfunction

endpackage

// File: design/usan_front.sv
// front end: parses input beats and issues emit commands
module usan_front import usan_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_data,
  input  logic       in_eos,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       q_ready
);

  logic [2:0][7:0] pend_r;
  logic [2:0][7:0] pend_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [2:0]      exp_r, exp_nxt;
  logic            inv_r, inv_nxt;
  logic            acc;
  logic            do_lead;
  logic            ok;
  logic [2:0]      lead;
  logic            any_repl;
  cmd_t            cmd;

  assign in_tready = q_ready;
  assign acc       = in_tvalid && in_tready;
  assign lead      = lead_len(in_data);

  always_comb begin
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    exp_nxt       = exp_r;
    inv_nxt       = inv_r;
    do_lead       = 1'b0;
    cmd.seq       = {8'h00, pend_r[2], pend_r[1], pend_r[0]};
    cmd.seq_len   = 3'd0;
    cmd.r_pre     = 3'd0;
    cmd.r_post    = 2'd0;
    cmd.eos       = in_eos;
    cmd.all_valid = 1'b0;
    ok = (cnt_r == 2'd1) ? second_ok(pend_r[0], in_data) : is_cont(in_data);
    if (cnt_r == 2'd0) begin
      do_lead = 1'b1;
    end else if (ok) begin
      if (({1'b0, cnt_r} + 3'd1) >= exp_r) begin
        cmd.seq[cnt_r] = in_data;
        cmd.seq_len    = {1'b0, cnt_r} + 3'd1;
        cnt_nxt        = 2'd0;
        exp_nxt        = 3'd0;
      end else begin
        pend_nxt[cnt_r] = in_data;
        cnt_nxt         = cnt_r + 2'd1;
      end
    end else begin
      cmd.r_pre = {1'b0, cnt_r};
      cnt_nxt   = 2'd0;
      exp_nxt   = 3'd0;
      do_lead   = 1'b1;
    end
    if (do_lead) begin
      if (lead == LEN_ASCII) begin
        cmd.seq[0]  = in_data;
        cmd.seq_len = 3'd1;
      end else if (lead == LEN_BAD) begin
        cmd.r_pre = cmd.r_pre + 3'd1;
      end else begin
        pend_nxt[0] = in_data;
        cnt_nxt     = 2'd1;
        exp_nxt     = lead;
      end
    end
    any_repl = (cmd.r_pre != 3'd0);
    if (in_eos) begin
      // unfinished sequence at end of string: one replacement per held byte
      cmd.r_post    = cnt_nxt;
      any_repl      = any_repl || (cnt_nxt != 2'd0);
      cmd.all_valid = !(inv_r || any_repl);
      cnt_nxt       = 2'd0;
      exp_nxt       = 3'd0;
      inv_nxt       = 1'b0;
    end else begin
      inv_nxt = inv_r || any_repl;
    end
  end

  assign push_cmd = cmd;
  assign push = acc && (in_eos || (cmd.seq_len != 3'd0) || (cmd.r_pre != 3'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      exp_r <= 3'd0;
      inv_r <= 1'b0;
    end else if (acc) begin
      cnt_r <= cnt_nxt;
      exp_r <= exp_nxt;
      inv_r <= inv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

// File: design/usan_queue.sv
// short command queue between front and back end
module usan_queue import usan_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic q_ready,
  output logic q_valid,
  output cmd_t head,
  input  logic pop
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign q_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: design/usan_back.sv
// back end: budget check and byte-by-byte emission of commands
module usan_back import usan_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  cmd_t                    head,
  output logic                    pop,
  input  logic [BUDGET_WIDTH-1:0] max_bytes,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [7:0]              out_byte,
  output logic                    out_present,
  output logic                    out_last,
  output logic                    out_trunc,
  output logic                    out_valid
);

  localparam int SW = BUDGET_WIDTH + 1;

  logic [BUDGET_WIDTH-1:0] be_r, be_nxt;
  logic                    stop_r, stop_nxt;
  logic [2:0]              u_r, u_nxt;
  logic [1:0]              j_r, j_nxt;
  logic                    any_r, any_nxt;
  logic                    ov_r, ov_nxt;
  logic                    load;
  logic [7:0]              byte_nxt;
  logic                    pres_nxt, last_nxt, trunc_nxt, valid_nxt;
  logic [7:0]              byte_r;
  logic                    pres_r, last_r, trunc_r, valid_r;
  logic                    can_emit;
  logic [2:0]              n_units, len_cur, len_next;
  logic                    last_unit, is_seq, fit_cur, fit_next, last_byte;
  logic [SW-1:0]           be_base;
  logic [SW-1:0]           max_ext;
  logic [7:0]              repl_byte;

  function automatic logic [2:0] unit_len(input cmd_t c, input logic [2:0] u,
                                          input logic [2:0] n);
    logic [2:0] l;
    if (u >= n) l = 3'd0;
    else if ((u == c.r_pre) && (c.seq_len != 3'd0)) l = c.seq_len;
    else l = LEN_REPL;
    return l;
  endfunction

  assign can_emit  = !ov_r || out_tready;
  assign n_units   = head.r_pre + {2'b00, (head.seq_len != 3'd0)} + {1'b0, head.r_post};
  assign len_cur   = unit_len(head, u_r, n_units);
  assign len_next  = unit_len(head, u_r + 3'd1, n_units);
  assign last_unit = ((u_r + 3'd1) == n_units);
  assign is_seq    = (u_r == head.r_pre) && (head.seq_len != 3'd0);
  assign max_ext   = {1'b0, max_bytes};
  assign fit_cur   = (j_r != 2'd0) || (({1'b0, be_r} + SW'(len_cur)) <= max_ext);
  assign be_base   = (j_r == 2'd0) ? ({1'b0, be_r} + SW'(len_cur)) : {1'b0, be_r};
  assign fit_next  = (len_next == 3'd0) || ((be_base + SW'(len_next)) <= max_ext);
  assign last_byte = ({1'b0, j_r} == (len_cur - 3'd1));

  always_comb begin
    case (j_r)
      2'd0:    repl_byte = REPL_B0;
      2'd1:    repl_byte = REPL_B1;
      default: repl_byte = REPL_B2;
    endcase
  end

  always_comb begin
    be_nxt    = be_r;
    stop_nxt  = stop_r;
    u_nxt     = u_r;
    j_nxt     = j_r;
    any_nxt   = any_r;
    pop       = 1'b0;
    load      = 1'b0;
    byte_nxt  = 8'h00;
    pres_nxt  = 1'b0;
    last_nxt  = 1'b0;
    trunc_nxt = 1'b0;
    valid_nxt = 1'b0;
    if (q_valid && can_emit) begin
      if ((n_units == 3'd0) || stop_r || !fit_cur) begin
        // nothing more to send for this command; end marker if string ends bare
        pop       = 1'b1;
        load      = head.eos && !any_r;
        last_nxt  = 1'b1;
        trunc_nxt = 1'b1;
        trunc_nxt = stop_r || (n_units != 3'd0);
        valid_nxt = head.all_valid;
        stop_nxt  = stop_r || (n_units != 3'd0);
        u_nxt     = 3'd0;
        j_nxt     = 2'd0;
        any_nxt   = 1'b0;
        if (head.eos) begin
          be_nxt   = '0;
          stop_nxt = 1'b0;
        end
      end else begin
        load     = 1'b1;
        byte_nxt = is_seq ? head.seq[j_r] : repl_byte;
        pres_nxt = 1'b1;
        any_nxt  = 1'b1;
        if (j_r == 2'd0) be_nxt = be_base[BUDGET_WIDTH-1:0];
        if (last_byte) begin
          if (last_unit || !fit_next) begin
            pop       = 1'b1;
            last_nxt  = head.eos;
            trunc_nxt = head.eos && !fit_next;
            valid_nxt = head.eos && head.all_valid;
            stop_nxt  = !fit_next;
            u_nxt     = 3'd0;
            j_nxt     = 2'd0;
            any_nxt   = 1'b0;
            if (head.eos) begin
              be_nxt   = '0;
              stop_nxt = 1'b0;
            end
          end else begin
            u_nxt = u_r + 3'd1;
            j_nxt = 2'd0;
          end
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
    end
    if (load) ov_nxt = 1'b1;
    else if (out_tready) ov_nxt = 1'b0;
    else ov_nxt = ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      be_r   <= '0;
      stop_r <= 1'b0;
      u_r    <= 3'd0;
      j_r    <= 2'd0;
      any_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      be_r   <= be_nxt;
      stop_r <= stop_nxt;
      u_r    <= u_nxt;
      j_r    <= j_nxt;
      any_r  <= any_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= byte_nxt;
      pres_r  <= pres_nxt;
      last_r  <= last_nxt;
      trunc_r <= trunc_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_tvalid  = ov_r;
  assign out_byte    = byte_r;
  assign out_present = pres_r;
  assign out_last    = last_r;
  assign out_trunc   = trunc_r;
  assign out_valid   = valid_r;

endmodule

// File: design/utf8_bounded_sanitizer_top.sv
// top level of the utf-8 sanitiser with output byte budget
//
// input stream: one raw string byte per beat in in_tdata, in_tlast on the
// final byte of a string. output stream: one byte per beat, either passed
// through or part of an ef bf bd replacement; out_tlast marks the final beat
// of a string, which also carries the truncated and all-valid flags. a string
// whose end step emits nothing gets a bare end marker (out_tuser low).
// cfg_wr_en/cfg_wr_data set the per-string byte budget (reset 200); write it
// only while the block is idle.
// throughput: one input beat per cycle while output flows; one output beat
// per cycle, set by the single output register. a replacement expands to
// three beats, so bursts are soaked up by the four-entry command queue and
// in_tready drops once it fills.
// reset clears the parser state, the queue and the output valid flag; the budget
// goes back to 200. when out_tready is low the output beat holds and the
// front keeps taking bytes until the queue is full.
module utf8_bounded_sanitizer_top import usan_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // config port
  input  logic                 cfg_wr_en,
  input  logic [CFG_WIDTH-1:0] cfg_wr_data,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_byte
  input  logic                 in_tlast,   // end_of_string
  // output stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [7:0] out_byte, [8] was_truncated, [9] all_valid
  output logic                 out_tuser,  // [0] byte_present
  output logic                 out_tlast   // last_of_run
);

  logic [BUDGET_WIDTH-1:0] max_r, max_nxt;
  logic                    push, q_ready, q_valid, pop;
  cmd_t                    push_cmd, head;
  logic [7:0]              ob;
  logic                    otrunc, ovalid;

  // budget register, loaded with the full written value on cfg_wr_en
  assign max_nxt = cfg_wr_en ? BUDGET_WIDTH'(cfg_wr_data) : max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= BUDGET_WIDTH'(BUDGET_RESET);
    end else begin
      max_r <= max_nxt;
    end
  end

  // parser: at most one command per accepted beat
  usan_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_data   (in_tdata),
    .in_eos    (in_tlast),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_ready   (q_ready)
  );

  // decouples parsing from replacement bursts and output stalls
  usan_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop)
  );

  // budget accounting and byte emission
  usan_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .max_bytes   (max_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_byte    (ob),
    .out_present (out_tuser),
    .out_last    (out_tlast),
    .out_trunc   (otrunc),
    .out_valid   (ovalid)
  );

  assign out_tdata = {6'b000000, ovalid, otrunc, ob};

  // the front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_ready) else $error("command queue overflow");

  // a bare end marker is always the final beat of a string
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast) else $error("bare marker without tlast");

  // status flags ride only on the final beat
  a_flags_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (!out_tdata[8] && !out_tdata[9]))
    else $error("status flags on a non-final beat");

  // nothing is popped from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("command queue underflow");

  // output is empty the cycle after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("output valid after reset");

endmodule
